### rtl/core/tvot_pkg.sv
`timescale 1ns / 1ps
package tvot_pkg;

  localparam int GRID_LEVELS_DEF = 6;
  localparam int COORD_W         = 32;
  localparam int SIZE_W          = 31;
  localparam int IDX_W           = 6;
  localparam int MAG_W           = COORD_W + 1;
  localparam int DEN_W           = COORD_W + 1;
  localparam int LERP_LAT        = MAG_W + 4;
  localparam int FACE_LAT        = 2 * LERP_LAT + 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int S_TDATA_W       = 312;
  localparam int M_TDATA_W       = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // signed width of a box bound: origin + index * size + size
  function automatic int bound_w(input int gl);
    return ((gl < IDX_W) ? gl : IDX_W) + COORD_W + 2;
  endfunction

  // queue entry: vertices, then lo x/y/z, then hi x/y/z
  function automatic int item_w(input int bw);
    return 9 * COORD_W + 6 * bw;
  endfunction

endpackage

### rtl/core/tvot_lerp.sv
`timescale 1ns / 1ps
module tvot_lerp #(
  parameter int NUM_W = tvot_pkg::bound_w(tvot_pkg::GRID_LEVELS_DEF) + 1
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tvot_pkg::COORD_W-1:0] p0,
  input  logic signed [tvot_pkg::COORD_W-1:0] p1,
  input  logic signed [NUM_W-1:0]             num,
  input  logic signed [tvot_pkg::DEN_W-1:0]   den,
  output logic signed [tvot_pkg::COORD_W-1:0] res
);
  import tvot_pkg::*;

  localparam int LH = (MAG_W + 1) / 2;
  localparam int HH = MAG_W - LH;
  localparam int PW = 2 * MAG_W;

  logic signed [DEN_W:0]   den_x, den_a;
  logic signed [NUM_W:0]   num_x, num_f;
  logic [MAG_W-1:0]        numc;
  logic signed [MAG_W-1:0] delta;
  logic [MAG_W-1:0]        mag;

  always_comb begin
    den_x = {den[DEN_W-1], den};
    den_a = den[DEN_W-1] ? -den_x : den_x;
    num_x = {num[NUM_W-1], num};
    num_f = den[DEN_W-1] ? -num_x : num_x;
    if (num_f[NUM_W]) begin
      numc = '0;
    end else if ($unsigned(num_f) > (NUM_W+1)'(den_a[MAG_W-1:0])) begin
      numc = den_a[MAG_W-1:0];
    end else begin
      numc = num_f[MAG_W-1:0];
    end
    delta = {p1[COORD_W-1], p1} - {p0[COORD_W-1], p0};
    mag   = delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
  end

  logic [MAG_W-1:0]          s1_den, s1_num, s1_mag;
  logic                      s1_neg, s2_neg;
  logic signed [COORD_W-1:0] s1_p0, s2_p0;
  logic [MAG_W-1:0]          s2_den;
  logic [MAG_W+LH-1:0]       pp_lo;
  logic [MAG_W+HH-1:0]       pp_hi;
  logic [PW-1:0]             prod;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_den <= den_a[MAG_W-1:0];
      s1_num <= numc;
      s1_mag <= mag;
      s1_neg <= delta[MAG_W-1];
      s1_p0  <= p0;
      pp_lo  <= (MAG_W+LH)'(s1_mag) * (MAG_W+LH)'(s1_num[LH-1:0]);
      pp_hi  <= (MAG_W+HH)'(s1_mag) * (MAG_W+HH)'(s1_num[MAG_W-1:LH]);
      s2_den <= s1_den;
      s2_neg <= s1_neg;
      s2_p0  <= s1_p0;
    end
  end

  assign prod = PW'(pp_lo) + {pp_hi, {LH{1'b0}}};

  // restoring divide, one quotient bit per stage
  logic [MAG_W-1:0]          rem [MAG_W+1];
  logic [MAG_W-1:0]          dlo [MAG_W+1];
  logic [MAG_W-1:0]          quo [MAG_W+1];
  logic [MAG_W-1:0]          dv  [MAG_W+1];
  logic                      ng  [MAG_W+1];
  logic signed [COORD_W-1:0] pz  [MAG_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= prod[PW-1:MAG_W];
      dlo[0] <= prod[MAG_W-1:0];
      quo[0] <= '0;
      dv[0]  <= s2_den;
      ng[0]  <= s2_neg;
      pz[0]  <= s2_p0;
    end
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_div
    logic [MAG_W:0] trial, diff;
    logic           ge;
    always_comb begin
      trial = {rem[k], dlo[k][MAG_W-1]};
      diff  = trial - {1'b0, dv[k]};
      ge    = trial >= {1'b0, dv[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        dlo[k+1] <= {dlo[k][MAG_W-2:0], 1'b0};
        quo[k+1] <= {quo[k][MAG_W-2:0], ge};
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        pz[k+1]  <= pz[k];
      end
    end
  end

  logic signed [COORD_W+1:0] fin;

  always_comb begin
    if (ng[MAG_W]) begin
      fin = {{2{pz[MAG_W][COORD_W-1]}}, pz[MAG_W]} - {1'b0, quo[MAG_W]};
    end else begin
      fin = {{2{pz[MAG_W][COORD_W-1]}}, pz[MAG_W]} + {1'b0, quo[MAG_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= fin[COORD_W-1:0];
    end
  end

endmodule

### rtl/core/tvot_face.sv
`timescale 1ns / 1ps
module tvot_face #(
  parameter int BOUND_W = tvot_pkg::bound_w(tvot_pkg::GRID_LEVELS_DEF)
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tvot_pkg::COORD_W-1:0] pc [3],
  input  logic signed [tvot_pkg::COORD_W-1:0] uc [3],
  input  logic signed [tvot_pkg::COORD_W-1:0] vc [3],
  input  logic signed [BOUND_W-1:0]           f,
  input  logic signed [BOUND_W-1:0]           ulo,
  input  logic signed [BOUND_W-1:0]           uhi,
  input  logic signed [BOUND_W-1:0]           vlo,
  input  logic signed [BOUND_W-1:0]           vhi,
  output logic                                hit
);
  import tvot_pkg::*;

  localparam int NW = BOUND_W + 1;

  typedef struct packed {
    logic                     skip;
    logic [1:0]               ok;
    logic signed [BOUND_W-1:0] ulo;
    logic signed [BOUND_W-1:0] uhi;
    logic signed [BOUND_W-1:0] vlo;
    logic signed [BOUND_W-1:0] vhi;
  } ctl1_t;

  typedef struct packed {
    logic                     skip;
    logic                     okall;
    logic                     sqhit;
    logic [3:0]               pass;
    logic signed [BOUND_W-1:0] ulo;
    logic signed [BOUND_W-1:0] uhi;
    logic signed [BOUND_W-1:0] vlo;
    logic signed [BOUND_W-1:0] vhi;
  } ctl2_t;

  function automatic logic signed [BOUND_W-1:0] sx(input logic signed [COORD_W-1:0] a);
    return {{(BOUND_W-COORD_W){a[COORD_W-1]}}, a};
  endfunction

  function automatic logic signed [NW-1:0] nx(input logic signed [COORD_W-1:0] a);
    return {{(NW-COORD_W){a[COORD_W-1]}}, a};
  endfunction

  // cut points from the odd vertex toward the other two
  logic [2:0]   gt, lt;
  logic         ab_pos, ac_pos;
  logic [1:0]   odd, e0, e1;
  logic signed [NW-1:0]    num_a;
  logic signed [DEN_W-1:0] den_a [2];
  ctl1_t        c1_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gt[i] = sx(pc[i]) > f;
      lt[i] = sx(pc[i]) < f;
    end
    ab_pos = (gt[0] & gt[1]) | (lt[0] & lt[1]);
    ac_pos = (gt[0] & gt[2]) | (lt[0] & lt[2]);
    if (ab_pos) begin
      e0 = 2'd0; e1 = 2'd1; odd = 2'd2;
    end else if (ac_pos) begin
      e0 = 2'd0; e1 = 2'd2; odd = 2'd1;
    end else begin
      e0 = 2'd2; e1 = 2'd1; odd = 2'd0;
    end
    num_a    = {f[BOUND_W-1], f} - nx(pc[odd]);
    den_a[0] = {pc[e0][COORD_W-1], pc[e0]} - {pc[odd][COORD_W-1], pc[odd]};
    den_a[1] = {pc[e1][COORD_W-1], pc[e1]} - {pc[odd][COORD_W-1], pc[odd]};
    c1_in.skip  = ab_pos & ac_pos;
    c1_in.ok[0] = den_a[0] != '0;
    c1_in.ok[1] = den_a[1] != '0;
    c1_in.ulo   = ulo;
    c1_in.uhi   = uhi;
    c1_in.vlo   = vlo;
    c1_in.vhi   = vhi;
  end

  logic signed [NW-1:0]      a_num;
  logic signed [DEN_W-1:0]   a_den [2];
  logic signed [COORD_W-1:0] a_u0, a_v0;
  logic signed [COORD_W-1:0] a_u [2];
  logic signed [COORD_W-1:0] a_v [2];
  ctl1_t                     d1 [LERP_LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a_num    <= num_a;
      a_den[0] <= den_a[0];
      a_den[1] <= den_a[1];
      a_u0     <= uc[odd];
      a_v0     <= vc[odd];
      a_u[0]   <= uc[e0];
      a_u[1]   <= uc[e1];
      a_v[0]   <= vc[e0];
      a_v[1]   <= vc[e1];
      d1[0]    <= c1_in;
      for (int i = 1; i <= LERP_LAT; i++) begin
        d1[i] <= d1[i-1];
      end
    end
  end

  logic signed [COORD_W-1:0] pu [2];
  logic signed [COORD_W-1:0] pv [2];

  for (genvar k = 0; k < 2; k++) begin : g_cut
    tvot_lerp #(.NUM_W(NW)) u_lerp_u (
      .clk (clk), .en (en), .p0 (a_u0), .p1 (a_u[k]),
      .num (a_num), .den (a_den[k]), .res (pu[k])
    );
    tvot_lerp #(.NUM_W(NW)) u_lerp_v (
      .clk (clk), .en (en), .p0 (a_v0), .p1 (a_v[k]),
      .num (a_num), .den (a_den[k]), .res (pv[k])
    );
  end

  // square test and setup of the edge crossings on ulo, uhi, vlo and vhi
  ctl1_t                     c1;
  ctl2_t                     c2_in;
  logic [1:0]                insq;
  logic signed [COORD_W-1:0] au [4];
  logic signed [COORD_W-1:0] av [4];
  logic signed [COORD_W-1:0] bu [4];
  logic signed [COORD_W-1:0] bv [4];
  logic signed [BOUND_W-1:0] ee [4];
  logic signed [NW-1:0]      e_num [4];
  logic signed [DEN_W-1:0]   e_den [4];

  always_comb begin
    c1 = d1[LERP_LAT];
    for (int k = 0; k < 2; k++) begin
      insq[k] = c1.ok[k] && sx(pu[k]) >= c1.ulo && sx(pu[k]) <= c1.uhi
                && sx(pv[k]) >= c1.vlo && sx(pv[k]) <= c1.vhi;
    end
    for (int j = 0; j < 4; j++) begin
      if (j < 2) begin
        au[j] = pu[0]; av[j] = pv[0]; bu[j] = pu[1]; bv[j] = pv[1];
      end else begin
        au[j] = pv[0]; av[j] = pu[0]; bu[j] = pv[1]; bv[j] = pu[1];
      end
    end
    ee[0] = c1.ulo;
    ee[1] = c1.uhi;
    ee[2] = c1.vlo;
    ee[3] = c1.vhi;
    for (int j = 0; j < 4; j++) begin
      e_num[j] = {ee[j][BOUND_W-1], ee[j]} - nx(au[j]);
      e_den[j] = {bu[j][COORD_W-1], bu[j]} - {au[j][COORD_W-1], au[j]};
      c2_in.pass[j] = !((sx(au[j]) > ee[j] && sx(bu[j]) > ee[j])
                        || (sx(au[j]) < ee[j] && sx(bu[j]) < ee[j]))
                      && e_den[j] != '0;
    end
    c2_in.skip  = c1.skip;
    c2_in.okall = &c1.ok;
    c2_in.sqhit = |insq;
    c2_in.ulo   = c1.ulo;
    c2_in.uhi   = c1.uhi;
    c2_in.vlo   = c1.vlo;
    c2_in.vhi   = c1.vhi;
  end

  logic signed [NW-1:0]      b_num [4];
  logic signed [DEN_W-1:0]   b_den [4];
  logic signed [COORD_W-1:0] b_p0 [4];
  logic signed [COORD_W-1:0] b_p1 [4];
  ctl2_t                     d2 [LERP_LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        b_num[j] <= e_num[j];
        b_den[j] <= e_den[j];
        b_p0[j]  <= av[j];
        b_p1[j]  <= bv[j];
      end
      d2[0] <= c2_in;
      for (int i = 1; i <= LERP_LAT; i++) begin
        d2[i] <= d2[i-1];
      end
    end
  end

  logic signed [COORD_W-1:0] ev [4];

  for (genvar j = 0; j < 4; j++) begin : g_cross
    tvot_lerp #(.NUM_W(NW)) u_lerp_e (
      .clk (clk), .en (en), .p0 (b_p0[j]), .p1 (b_p1[j]),
      .num (b_num[j]), .den (b_den[j]), .res (ev[j])
    );
  end

  ctl2_t      c2;
  logic [3:0] ehit;

  always_comb begin
    c2 = d2[LERP_LAT];
    for (int j = 0; j < 4; j++) begin
      if (j < 2) begin
        ehit[j] = c2.pass[j] && sx(ev[j]) >= c2.vlo && sx(ev[j]) <= c2.vhi;
      end else begin
        ehit[j] = c2.pass[j] && sx(ev[j]) >= c2.ulo && sx(ev[j]) <= c2.uhi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= !c2.skip && (c2.sqhit || (c2.okall && |ehit));
    end
  end

endmodule

### rtl/core/tvot_front.sv
`timescale 1ns / 1ps
module tvot_front #(
  parameter int GRID_LEVELS = tvot_pkg::GRID_LEVELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [tvot_pkg::S_TDATA_W-1:0]        s_tdata,
  input  logic signed [tvot_pkg::COORD_W-1:0]   origin_x,
  input  logic signed [tvot_pkg::COORD_W-1:0]   origin_y,
  input  logic signed [tvot_pkg::COORD_W-1:0]   origin_z,
  input  logic [tvot_pkg::SIZE_W-1:0]           size_x,
  input  logic [tvot_pkg::SIZE_W-1:0]           size_y,
  input  logic [tvot_pkg::SIZE_W-1:0]           size_z,
  input  tvot_pkg::fifo_stat_t                  stat,
  output logic                                  push,
  output logic [tvot_pkg::item_w(tvot_pkg::bound_w(GRID_LEVELS))-1:0] item
);
  import tvot_pkg::*;

  localparam int IW = (GRID_LEVELS < IDX_W) ? GRID_LEVELS : IDX_W;
  localparam int PW = IW + SIZE_W;
  localparam int BW = bound_w(GRID_LEVELS);
  localparam int VW = 9 * COORD_W;

  logic          en, v1, v2;
  logic [VW-1:0] vtx1, vtx2;
  logic [IW-1:0] ix1, iy1, iz1;
  logic [PW-1:0] px, py, pz;
  logic signed [BW-1:0] lox, loy, loz, hix, hiy, hiz;

  assign en       = !v2 || !stat.full;
  assign s_tready = en;
  assign push     = v2 && !stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtx1 <= s_tdata[VW-1:0];
      ix1  <= s_tdata[VW +: IW];
      iy1  <= s_tdata[VW + IDX_W +: IW];
      iz1  <= s_tdata[VW + 2 * IDX_W +: IW];
      vtx2 <= vtx1;
      px   <= PW'(ix1) * PW'(size_x);
      py   <= PW'(iy1) * PW'(size_y);
      pz   <= PW'(iz1) * PW'(size_z);
    end
  end

  always_comb begin
    lox  = BW'(origin_x) + BW'(px);
    loy  = BW'(origin_y) + BW'(py);
    loz  = BW'(origin_z) + BW'(pz);
    hix  = lox + BW'(size_x);
    hiy  = loy + BW'(size_y);
    hiz  = loz + BW'(size_z);
    item = {hiz, hiy, hix, loz, loy, lox, vtx2};
  end

endmodule

### rtl/core/tvot_fifo.sv
`timescale 1ns / 1ps
module tvot_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = tvot_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [W-1:0]         din,
  input  logic                 pop,
  output logic [W-1:0]         dout,
  output tvot_pkg::fifo_stat_t stat
);
  import tvot_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;

  assign stat.full  = cnt == (AW+1)'(DEPTH);
  assign stat.empty = cnt == '0;
  assign dout       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

### rtl/core/tvot_back.sv
`timescale 1ns / 1ps
module tvot_back #(
  parameter int BOUND_W = tvot_pkg::bound_w(tvot_pkg::GRID_LEVELS_DEF)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [tvot_pkg::item_w(BOUND_W)-1:0]  item,
  input  tvot_pkg::fifo_stat_t                  stat,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [tvot_pkg::M_TDATA_W-1:0]        m_tdata // [0] overlaps
);
  import tvot_pkg::*;

  localparam int VW = 9 * COORD_W;
  localparam int P_AX [6] = '{0, 0, 1, 1, 2, 2};
  localparam int U_AX [6] = '{1, 1, 0, 0, 1, 1};
  localparam int V_AX [6] = '{2, 2, 2, 2, 0, 0};

  function automatic logic signed [BOUND_W-1:0] sx(input logic signed [COORD_W-1:0] a);
    return {{(BOUND_W-COORD_W){a[COORD_W-1]}}, a};
  endfunction

  logic                         en, s0v, ov;
  logic [item_w(BOUND_W)-1:0]   item0;
  logic signed [COORD_W-1:0]    vc [3][3];
  logic signed [BOUND_W-1:0]    lo [3];
  logic signed [BOUND_W-1:0]    hi [3];
  logic [2:0]                   vin;
  logic                         vhit;
  logic signed [COORD_W-1:0]    fp [6][3];
  logic signed [COORD_W-1:0]    fu [6][3];
  logic signed [COORD_W-1:0]    fv [6][3];
  logic signed [BOUND_W-1:0]    ff [6];
  logic [5:0]                   fhit;
  logic                         vh_d [FACE_LAT];
  logic                         vv [FACE_LAT];

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0v <= 1'b0;
    end else if (en) begin
      s0v <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item0 <= item;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        vc[i][k] = item0[(3 * i + k) * COORD_W +: COORD_W];
      end
    end
    for (int k = 0; k < 3; k++) begin
      lo[k] = item0[VW + k * BOUND_W +: BOUND_W];
      hi[k] = item0[VW + (3 + k) * BOUND_W +: BOUND_W];
    end
    for (int i = 0; i < 3; i++) begin
      vin[i] = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (sx(vc[i][k]) < lo[k] || sx(vc[i][k]) > hi[k]) begin
          vin[i] = 1'b0;
        end
      end
    end
    vhit = |vin;
    for (int g = 0; g < 6; g++) begin
      for (int i = 0; i < 3; i++) begin
        fp[g][i] = vc[i][P_AX[g]];
        fu[g][i] = vc[i][U_AX[g]];
        fv[g][i] = vc[i][V_AX[g]];
      end
      ff[g] = (g % 2 == 1) ? hi[P_AX[g]] : lo[P_AX[g]];
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_face
    tvot_face #(.BOUND_W(BOUND_W)) u_face (
      .clk (clk),
      .en  (en),
      .pc  (fp[g]),
      .uc  (fu[g]),
      .vc  (fv[g]),
      .f   (ff[g]),
      .ulo (lo[U_AX[g]]),
      .uhi (hi[U_AX[g]]),
      .vlo (lo[V_AX[g]]),
      .vhi (hi[V_AX[g]]),
      .hit (fhit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vh_d[0] <= vhit;
      for (int i = 1; i < FACE_LAT; i++) begin
        vh_d[i] <= vh_d[i-1];
      end
      ov <= vh_d[FACE_LAT-1] | (|fhit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FACE_LAT; i++) begin
        vv[i] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (en) begin
      vv[0] <= s0v;
      for (int i = 1; i < FACE_LAT; i++) begin
        vv[i] <= vv[i-1];
      end
      m_tvalid <= vv[FACE_LAT-1];
    end
  end

  assign m_tdata = {{(M_TDATA_W-1){1'b0}}, ov};

endmodule

### rtl/core/triangle_voxel_overlap_test_core.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle without output stalls; the back end runs
// 6 face units, each two chained 37-stage projection dividers, all advancing together.
// A 4-entry queue separates front end and back end so each stalls on its own.
// Reset (rst, sync, active high) empties the pipe and restores the register defaults.
module triangle_voxel_overlap_test_core #(
  parameter int GRID_LEVELS = tvot_pkg::GRID_LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // vertex_a_x/y/z, vertex_b_x/y/z, vertex_c_x/y/z, voxel_ix, voxel_iy, voxel_iz
  input  logic [tvot_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tvot_pkg::M_TDATA_W-1:0]   m_tdata, // overlaps
  input  logic                             cfg_wen,
  input  logic [tvot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvot_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tvot_pkg::*;

  localparam int BW = bound_w(GRID_LEVELS);
  localparam int IW = item_w(BW);

  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic [SIZE_W-1:0]         size_x, size_y, size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= -COORD_W'(32'sd1966080);
      origin_y <= -COORD_W'(32'sd1966080);
      origin_z <= -COORD_W'(32'sd1966080);
      size_x   <= SIZE_W'(61440);
      size_y   <= SIZE_W'(61440);
      size_z   <= SIZE_W'(61440);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        REG_SIZE_X:   size_x   <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:   size_y   <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:   size_z   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  fifo_stat_t    stat;
  logic          push, pop;
  logic [IW-1:0] item_in, item_out;

  tvot_front #(.GRID_LEVELS(GRID_LEVELS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .size_x   (size_x),
    .size_y   (size_y),
    .size_z   (size_z),
    .stat     (stat),
    .push     (push),
    .item     (item_in)
  );

  tvot_fifo #(.W(IW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (item_in),
    .pop  (pop),
    .dout (item_out),
    .stat (stat)
  );

  tvot_back #(.BOUND_W(BW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .item     (item_out),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import tvot_pkg::*;

  typedef longint vtx_t [3][3];
  typedef struct {
    logic [31:0] v [9];
    logic [5:0]  idx [3];
  } item_t;

  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam int     WDOG_LIMIT = 5000;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [S_TDATA_W-1:0]    s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [M_TDATA_W-1:0]    m_tdata;
  logic                    cfg_wen;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  triangle_voxel_overlap_test_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint cur_origin [3];
  longint cur_size [3];
  bit     overlap_due [$];
  bit     idle_on;
  int     miss_cnt;
  int     sent_cnt;
  int     hit_cnt;
  int     wdog;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic int sgn(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic longint lerp(longint p0, longint p1, longint num, longint den);
    longint      d;
    logic [63:0] mag;
    logic [127:0] q;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0) num = 0;
    if (num > den) num = den;
    d = p1 - p0;
    mag = (d < 0) ? -d : d;
    q = ({64'd0, mag} * {64'd0, num}) / {64'd0, den};
    return (d < 0) ? p0 - longint'(q[63:0]) : p0 + longint'(q[63:0]);
  endfunction

  function automatic bit edge_cross(longint au, longint av, longint bu, longint bv,
                                    longint e, longint lo, longint hi);
    longint v;
    if (sgn(au - e) * sgn(bu - e) > 0) return 0;
    if (bu == au) return 0;
    v = lerp(av, bv, e - au, bu - au);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit face_hit(vtx_t t, int p, int u, int v, longint f,
                                  longint ulo, longint uhi, longint vlo, longint vhi);
    int     s0, s1, s2, odd;
    int     ends [2];
    longint pu [2];
    longint pv [2];
    bit     ok [2];
    longint den, num;
    s0 = sgn(t[0][p] - f);
    s1 = sgn(t[1][p] - f);
    s2 = sgn(t[2][p] - f);
    if (s0 * s1 > 0 && s0 * s2 > 0) return 0;
    if (s0 * s1 > 0) begin
      ends[0] = 0; ends[1] = 1; odd = 2;
    end else if (s0 * s2 > 0) begin
      ends[0] = 0; ends[1] = 2; odd = 1;
    end else begin
      ends[0] = 2; ends[1] = 1; odd = 0;
    end
    for (int k = 0; k < 2; k++) begin
      den = t[ends[k]][p] - t[odd][p];
      num = f - t[odd][p];
      ok[k] = den != 0;
      pu[k] = 0;
      pv[k] = 0;
      if (ok[k]) begin
        pu[k] = lerp(t[odd][u], t[ends[k]][u], num, den);
        pv[k] = lerp(t[odd][v], t[ends[k]][v], num, den);
        if (pu[k] >= ulo && pu[k] <= uhi && pv[k] >= vlo && pv[k] <= vhi) return 1;
      end
    end
    if (!ok[0] || !ok[1]) return 0;
    return edge_cross(pu[0], pv[0], pu[1], pv[1], ulo, vlo, vhi)
        || edge_cross(pu[0], pv[0], pu[1], pv[1], uhi, vlo, vhi)
        || edge_cross(pv[0], pu[0], pv[1], pu[1], vlo, ulo, uhi)
        || edge_cross(pv[0], pu[0], pv[1], pu[1], vhi, ulo, uhi);
  endfunction

  function automatic bit overlap_of(item_t it);
    vtx_t   t;
    longint lo [3];
    longint hi [3];
    bit     inb;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        t[i][k] = longint'(signed'(it.v[i*3+k]));
    for (int k = 0; k < 3; k++) begin
      lo[k] = cur_origin[k] + longint'(it.idx[k]) * cur_size[k];
      hi[k] = lo[k] + cur_size[k];
    end
    for (int i = 0; i < 3; i++) begin
      inb = 1;
      for (int k = 0; k < 3; k++)
        if (t[i][k] < lo[k] || t[i][k] > hi[k]) inb = 0;
      if (inb) return 1;
    end
    return face_hit(t, 0, 1, 2, lo[0], lo[1], hi[1], lo[2], hi[2])
        || face_hit(t, 0, 1, 2, hi[0], lo[1], hi[1], lo[2], hi[2])
        || face_hit(t, 1, 0, 2, lo[1], lo[0], hi[0], lo[2], hi[2])
        || face_hit(t, 1, 0, 2, hi[1], lo[0], hi[0], lo[2], hi[2])
        || face_hit(t, 2, 1, 0, lo[2], lo[1], hi[1], lo[0], hi[0])
        || face_hit(t, 2, 1, 0, hi[2], lo[1], hi[1], lo[0], hi[0]);
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic longint clamp32(longint x);
    return (x < I32_MIN) ? I32_MIN : ((x > I32_MAX) ? I32_MAX : x);
  endfunction

  function automatic item_t mk(longint a [9], int ix, int iy, int iz);
    item_t it;
    for (int i = 0; i < 9; i++) it.v[i] = a[i][31:0];
    it.idx[0] = ix[5:0];
    it.idx[1] = iy[5:0];
    it.idx[2] = iz[5:0];
    return it;
  endfunction

  // coordinate around the box along one axis, often right on a bound
  function automatic longint near_coord(longint lo, longint sz);
    longint r;
    case ($urandom_range(0, 5))
      0: return clamp32(lo);
      1: return clamp32(lo + sz);
      default: begin
        r = longint'({$urandom, $urandom} >> 1) % (3 * sz + 1);
        return clamp32(lo - sz + r);
      end
    endcase
  endfunction

  function automatic item_t rand_item(bit near);
    item_t  it;
    longint lo;
    longint c;
    int     same;
    for (int k = 0; k < 3; k++) it.idx[k] = 6'($urandom_range(0, 63));
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        lo = cur_origin[k] + longint'(it.idx[k]) * cur_size[k];
        c = near ? near_coord(lo, cur_size[k]) : longint'($urandom);
        it.v[i*3+k] = c[31:0];
      end
    // sometimes put two vertices on the same plane
    if (near && $urandom_range(0, 5) == 0) begin
      same = $urandom_range(0, 2);
      it.v[3+same] = it.v[same];
    end
    return it;
  endfunction

  task automatic send_tri(item_t it);
    logic [S_TDATA_W-1:0] d;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    d = '0;
    for (int i = 0; i < 9; i++) d[i*32 +: 32] = it.v[i];
    for (int k = 0; k < 3; k++) d[288 + k*6 +: 6] = it.idx[k];
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    overlap_due.push_back(overlap_of(it));
    sent_cnt++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (overlap_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_regs(longint ox, longint oy, longint oz,
                            longint sx, longint sy, longint sz);
    longint val [6];
    drain();
    val = '{ox, oy, oz, sx, sy, sz};
    for (int r = 0; r < 6; r++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_data  <= val[r][31:0];
      @(posedge clk);
      if (r < 3) cur_origin[r] = longint'(signed'(val[r][31:0]));
      else cur_size[r-3] = val[r] & 64'h7FFF_FFFF;
    end
    cfg_wen <= 1'b0;
  endtask

  // ---------------- tests ----------------
  task automatic test_directed;
    longint a [9];
    longint lo, hi;
    lo = -1966080 + 5 * 61440;
    hi = lo + 61440;
    a = '{lo + 100, lo + 100, lo + 100, 0, 0, 0, 1, 1, 1};
    send_tri(mk(a, 5, 5, 5));                               // vertex inside
    a = '{lo, lo, lo, I32_MAX, I32_MAX, I32_MAX, I32_MIN, I32_MIN, I32_MIN};
    send_tri(mk(a, 5, 5, 5));                               // corner touch
    a = '{hi, hi, hi, hi, hi, hi, hi, hi, hi};
    send_tri(mk(a, 5, 5, 5));                               // degenerate on corner
    a = '{I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN,
          I32_MIN, I32_MIN, I32_MIN};
    send_tri(mk(a, 0, 0, 0));
    a = '{I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MIN, I32_MAX,
          I32_MIN, I32_MAX, I32_MIN};
    send_tri(mk(a, 63, 63, 63));
    // large triangle slicing the box, no vertex inside
    a = '{lo - 400000, lo + 30000, lo - 400000, lo + 400000, lo + 30000, lo - 400000,
          lo, lo + 30000, lo + 400000};
    send_tri(mk(a, 5, 5, 5));
    // two vertices on the x face plane
    a = '{lo, lo - 10, lo - 10, lo, hi + 10, hi + 10, lo - 50000, lo, lo};
    send_tri(mk(a, 5, 5, 5));
    a = '{lo, lo - 90000, lo + 10, lo, lo - 80000, lo + 20, lo - 50000, lo, lo};
    send_tri(mk(a, 5, 5, 5));
    // cut segment crossing a face square edge only
    a = '{lo - 100000, lo - 20000, lo + 30000, lo + 100000, lo + 30000, lo - 100000,
          lo + 100000, lo + 30000, lo + 200000};
    send_tri(mk(a, 5, 5, 5));
    // z faces: near misses, just past the y bound, then just past the x bound
    a = '{lo + 30000, hi + 1, lo - 100000, lo + 30000, hi + 1, hi + 100000,
          lo + 30000, hi + 50000, lo};
    send_tri(mk(a, 5, 5, 5));
    a = '{hi + 1, lo + 30000, lo - 100000, hi + 1, lo + 30000, hi + 100000,
          hi + 50000, lo + 30000, lo};
    send_tri(mk(a, 5, 5, 5));
    a = '{lo - 1, lo - 1, lo - 1, lo - 2, lo - 3, lo - 4, lo - 9, lo - 1, lo - 1};
    send_tri(mk(a, 5, 5, 5));
    a = '{lo + 10, lo + 10, lo + 10, 0, 0, 0, 0, 0, 0};
    send_tri(mk(a, 0, 63, 5));
  endtask

  task automatic test_random(int n, int near_pct);
    for (int i = 0; i < n; i++)
      send_tri(rand_item($urandom_range(0, 99) < near_pct));
  endtask

  task automatic test_config_extremes;
    write_regs(I32_MIN, I32_MIN, I32_MIN, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
    test_random(200, 85);
    write_regs(I32_MAX, I32_MAX, I32_MAX, 1, 1, 1);
    test_random(150, 85);
    write_regs(0, 0, 0, 1, 1, 1);
    test_random(200, 85);
    write_regs(-1000000, 2000000, -300000, 12345, 700000, 65536);
    test_random(200, 85);
    write_regs(longint'(signed'($urandom)), longint'(signed'($urandom)),
               longint'(signed'($urandom)), $urandom_range(1, 32'h7FFF_FFFF),
               $urandom_range(1, 1000000), $urandom_range(1, 100));
    test_random(200, 85);
  endtask

  task automatic test_no_idle;
    write_regs(-1966080, -1966080, -1966080, 61440, 61440, 61440);
    idle_on = 0;
    test_random(300, 85);
  endtask

  // ---------------- result check ----------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (overlap_due.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10) $display("unexpected result overlaps=%0d", m_tdata[0]);
      end else begin
        if (m_tdata[0] !== overlap_due[0] || m_tdata[M_TDATA_W-1:1] !== '0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("mismatch: overlaps expected %0d actual %0h", overlap_due[0], m_tdata);
        end
        if (overlap_due[0]) hit_cnt++;
        void'(overlap_due.pop_front());
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    wdog = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("timeout: %0d results outstanding", overlap_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1;
    miss_cnt  = 0;
    sent_cnt  = 0;
    hit_cnt   = 0;
    for (int k = 0; k < 3; k++) begin
      cur_origin[k] = -1966080;
      cur_size[k]   = 61440;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(540, 80);
    test_config_extremes();
    test_no_idle();
    drain();
    $display("%0d triangles over 7 register settings, %0d overlapping", sent_cnt, hit_cnt);
    $display("%0d mismatches", miss_cnt);
    if (miss_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/tvot_pkg.sv
rtl/core/tvot_lerp.sv
rtl/core/tvot_face.sv
rtl/core/tvot_front.sv
rtl/core/tvot_fifo.sv
rtl/core/tvot_back.sv
rtl/core/triangle_voxel_overlap_test_core.sv
bench/tb.sv
